[rtl/core/heightmap_upsample_2x_defines.svh]
// Assertion macros shared by the heightmap upsampler RTL.
`ifndef HEIGHTMAP_UPSAMPLE_2X_DEFINES_SVH
`define HEIGHTMAP_UPSAMPLE_2X_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define HU2X_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("heightmap_upsample_2x: assertion failed");
// Condition that must never be true outside reset.
`define HU2X_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("heightmap_upsample_2x: forbidden condition seen");
`else
`define HU2X_ASSERT(label, prop)
`define HU2X_NEVER(label, cond)
`endif

`endif

[rtl/core/hu2x_pkg.sv]
// Shared widths, register indexes and point codes of the heightmap upsampler.
package hu2x_pkg;

    localparam int SAMPLE_W = 8;
    localparam int CFG_W    = 11;
    localparam int XZ_W     = 11;
    localparam int HQ_W     = 10;
    localparam int IDX_W    = 1;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SRC_DIM_RESET = 11'd256;

    // Bit positions in the pending-point mask; higher bit goes out first.
    localparam int PT_CENTER = 3;
    localparam int PT_VERT   = 2;
    localparam int PT_HORIZ  = 1;
    localparam int PT_SAMPLE = 0;
    localparam int PT_N      = 4;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [XZ_W-1:0]     coord_t;
    typedef logic [HQ_W-1:0]     height_t;
    typedef logic [CFG_W-1:0]    cfg_data_t;
    typedef logic [IDX_W-1:0]    cfg_index_t;
    typedef logic [PT_N-1:0]     pt_mask_t;

endpackage

[rtl/core/heightmap_upsample_2x.sv]
// Top level of the 2x bilinear heightmap upsampler.
// Throughput: one point per cycle while out_stall is low. The work stage holds one
// sample and takes the next as its last point leaves; out_valid for a first point
// rises once its sample is in the work stage and the point in the single output register.
// Reset clears counters, the left-neighbor register and config (both dimensions to 256);
// the row memory is not cleared and needs no clearing pass.
`include "heightmap_upsample_2x_defines.svh"

module heightmap_upsample_2x #(
    parameter int MAX_SRC_WIDTH  = 1024,
    parameter int MAX_SRC_HEIGHT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  hu2x_pkg::cfg_index_t  cfg_index,
    input  hu2x_pkg::cfg_data_t   cfg_data,
    // sample input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  hu2x_pkg::sample_t     sample,
    // point output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output hu2x_pkg::coord_t      out_x,
    output hu2x_pkg::coord_t      out_z,
    output hu2x_pkg::height_t     height_q,
    output logic                  last
);

    import hu2x_pkg::*;

    localparam int CW = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
    localparam int RW = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    // Doubled coordinates before masking to the output field width.
    localparam int XW = (CW + 1 > XZ_W) ? CW + 1 : XZ_W;
    localparam int ZW = (RW + 1 > XZ_W) ? RW + 1 : XZ_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_data_t src_width_reg;
    cfg_data_t src_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_DIM_RESET;
            src_height_reg <= SRC_DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and work-stage control
    // ------------------------------------------------------------------
    logic     busy_reg;        // work stage holds a sample with points pending
    pt_mask_t mask_reg;        // points of that sample still to emit
    logic     out_valid_reg;

    logic     in_accept;
    logic     out_free;
    logic     emit;
    logic     single_pt;
    logic     last_pt;

    // The output register can take a point when empty or being drained.
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = busy_reg && out_free;
    // Exactly one point left: this emission finishes the sample.
    assign single_pt = (mask_reg & (mask_reg - pt_mask_t'(1))) == '0;
    assign last_pt   = emit && single_pt;
    // Take a new sample when the stage is empty or its final point leaves now.
    assign in_stall  = busy_reg && !last_pt;
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Raster counters and left neighbor
    // ------------------------------------------------------------------
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    sample_t       left_reg;
    logic [CW:0]   col_plus;
    logic [RW:0]   row_plus;
    logic          col_wrap;
    logic          row_wrap;

    assign col_plus = (CW + 1)'(col_count_reg) + (CW + 1)'(1);
    assign row_plus = (RW + 1)'(row_count_reg) + (RW + 1)'(1);

    // A zero dimension acts as one, an oversize one as the maximum.
    assign col_wrap = (src_width_reg == '0)
                   || (32'(col_plus) >= 32'(src_width_reg))
                   || (32'(col_plus) >= 32'(MAX_SRC_WIDTH));
    assign row_wrap = (src_height_reg == '0)
                   || (32'(row_plus) >= 32'(src_height_reg))
                   || (32'(row_plus) >= 32'(MAX_SRC_HEIGHT));

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (col_wrap)
        begin
            col_count_next = '0;
            row_count_next = row_wrap ? '0 : row_plus[RW-1:0];
        end
        else
        begin
            col_count_next = col_plus[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            left_reg      <= '0;
        end
        else if (in_accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            left_reg      <= sample;
        end
    end

    // ------------------------------------------------------------------
    // Row memory: holds the previous source row, one byte per column.
    // Read and write share the address of the transfer; the read returns the
    // old entry (upper neighbor) while the new sample replaces it.
    // up_rd_reg changes only on a transfer, so it stays valid for the whole
    // time the sample sits in the work stage.
    // ------------------------------------------------------------------
    sample_t row_mem [MAX_SRC_WIDTH];
    sample_t up_rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            up_rd_reg              <= row_mem[col_count_reg];
            row_mem[col_count_reg] <= sample;
        end
    end

    // ------------------------------------------------------------------
    // Work stage payload
    // ------------------------------------------------------------------
    sample_t       s_reg;
    sample_t       l_reg;
    sample_t       ul_reg;
    logic [CW-1:0] c_reg;
    logic [RW-1:0] r_reg;

    // The previous sample's upper neighbor is still in up_rd_reg at the
    // transfer, so it becomes this sample's upper-left neighbor.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s_reg  <= sample;
            l_reg  <= left_reg;
            ul_reg <= up_rd_reg;
            c_reg  <= col_count_reg;
            r_reg  <= row_count_reg;
        end
    end

    pt_mask_t mask_init;
    always_comb
    begin
        mask_init            = '0;
        mask_init[PT_CENTER] = (row_count_reg != '0) && (col_count_reg != '0);
        mask_init[PT_VERT]   = (row_count_reg != '0);
        mask_init[PT_HORIZ]  = (col_count_reg != '0);
        mask_init[PT_SAMPLE] = 1'b1;
    end

    // ------------------------------------------------------------------
    // Point generation: pick the highest pending point in emission order
    // ------------------------------------------------------------------
    logic [XW-1:0] x_even;
    logic [XW-1:0] x_odd;
    logic [ZW-1:0] z_even;
    logic [ZW-1:0] z_odd;
    pt_mask_t      sel;
    coord_t        x_next;
    coord_t        z_next;
    height_t       h_next;

    assign x_even = XW'(c_reg) << 1;
    assign x_odd  = x_even - XW'(1);
    assign z_even = ZW'(r_reg) << 1;
    assign z_odd  = z_even - ZW'(1);

    always_comb
    begin
        sel    = '0;
        x_next = x_even[XZ_W-1:0];
        z_next = z_even[XZ_W-1:0];
        h_next = {s_reg, 2'b00};
        if (mask_reg[PT_CENTER])
        begin
            sel[PT_CENTER] = 1'b1;
            x_next = x_odd[XZ_W-1:0];
            z_next = z_odd[XZ_W-1:0];
            h_next = HQ_W'(ul_reg) + HQ_W'(up_rd_reg) + HQ_W'(l_reg) + HQ_W'(s_reg);
        end
        else if (mask_reg[PT_VERT])
        begin
            sel[PT_VERT] = 1'b1;
            z_next = z_odd[XZ_W-1:0];
            h_next = {(9'(up_rd_reg) + 9'(s_reg)), 1'b0};
        end
        else if (mask_reg[PT_HORIZ])
        begin
            sel[PT_HORIZ] = 1'b1;
            x_next = x_odd[XZ_W-1:0];
            h_next = {(9'(l_reg) + 9'(s_reg)), 1'b0};
        end
        else
        begin
            sel[PT_SAMPLE] = 1'b1;
        end
    end

    // Advance the work stage: load on transfer, drop emitted points.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mask_reg <= '0;
        end
        else if (in_accept)
        begin
            busy_reg <= 1'b1;
            mask_reg <= mask_init;
        end
        else if (last_pt)
        begin
            busy_reg <= 1'b0;
            mask_reg <= '0;
        end
        else if (emit)
        begin
            mask_reg <= mask_reg & ~sel;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold while stalled, reload when drained
    // ------------------------------------------------------------------
    coord_t  out_x_reg;
    coord_t  out_z_reg;
    height_t height_q_reg;
    logic    last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg    <= x_next;
            out_z_reg    <= z_next;
            height_q_reg <= h_next;
            last_reg     <= single_pt;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_z     = out_z_reg;
    assign height_q  = height_q_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The sample point itself is pending for as long as the stage is busy.
    `HU2X_NEVER(a_busy_has_sample, busy_reg && !mask_reg[PT_SAMPLE])
    // A transfer always leaves the work stage loaded.
    `HU2X_ASSERT(a_accept_loads, in_accept |=> busy_reg)
    // Finishing a sample frees the stage unless a new one came in behind it.
    `HU2X_ASSERT(a_last_frees, (last_pt && !in_valid) |=> !busy_reg)
    // The final point of a sample is the sample itself, on even coordinates.
    `HU2X_NEVER(a_last_even, out_valid_reg && last_reg && (out_x_reg[0] || out_z_reg[0]))

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the 2x bilinear heightmap upsampler.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hu2x_pkg::*;

    // Largest source dimension the block is built for (default parameters).
    localparam int unsigned SRC_MAX      = 1024;
    localparam int unsigned IDLE_PCT     = 28;
    localparam int unsigned RANDOM_ITEMS = 210;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned TAIL_CYCLES  = 16;
    localparam int unsigned LIMIT_CYCLES = 300000;
    localparam int unsigned EDGE_RUN     = 24;

    // One point of the upsampled grid as it leaves the block.
    typedef struct packed {
        coord_t  x;
        coord_t  z;
        height_t hq;
        logic    last;
    } point_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    cfg_index_t cfg_index = REG_SRC_WIDTH;
    cfg_data_t  cfg_data  = '0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    sample_t    sample    = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    coord_t     out_x;
    coord_t     out_z;
    height_t    height_q;
    logic       last;

    // Mirror of the block's state, advanced on every accepted sample.
    cfg_data_t   dim_width   = SRC_DIM_RESET;
    cfg_data_t   dim_height  = SRC_DIM_RESET;
    sample_t     row_mem[SRC_MAX];
    sample_t     left_byte   = '0;
    sample_t     upleft_byte = '0;
    int unsigned col_cnt     = 0;
    int unsigned row_cnt     = 0;
    // Number of row memory entries written so far, from index zero up.
    int unsigned written_span = 0;

    point_t      pending_points[$];
    int unsigned error_count    = 0;
    int unsigned samples_sent   = 0;
    int unsigned points_checked = 0;
    int unsigned dim_settings   = 0;
    int unsigned cycle_count    = 0;
    bit          steady         = 1'b0;

    heightmap_upsample_2x u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_z     (out_z),
        .height_q  (height_q),
        .last      (last)
    );

    always #1 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Stall the point channel at random; hold it open while steady is set.
    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Compare every point transfer with the oldest expected point.
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            points_checked++;
            if (pending_points.size() == 0)
            begin
                $error("point (%0d,%0d) with no expected point waiting", out_x, out_z);
                error_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (out_x !== want.x)
                begin
                    $error("out_x: expected %0d, got %0d", want.x, out_x);
                    error_count++;
                end
                if (out_z !== want.z)
                begin
                    $error("out_z: expected %0d, got %0d", want.z, out_z);
                    error_count++;
                end
                if (height_q !== want.hq)
                begin
                    $error("height_q: expected %0d, got %0d", want.hq, height_q);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    // A zero dimension acts as one, anything above the build maximum as the maximum.
    function automatic int unsigned eff_dim(input cfg_data_t d);
        if (d == 0)
            return 1;
        if (d > SRC_MAX)
            return SRC_MAX;
        return 32'(d);
    endfunction

    function automatic point_t make_point(input int unsigned x, input int unsigned z,
                                          input int unsigned hq);
        return point_t'{coord_t'(x), coord_t'(z), height_t'(hq), 1'b0};
    endfunction

    // Work out the points one sample completes, then advance the mirror state.
    task automatic predict_points(input sample_t s);
        int unsigned w, h, c, r, up, l, ul, sv, n;
        point_t pts[PT_N];
        point_t p;
        w  = eff_dim(dim_width);
        h  = eff_dim(dim_height);
        c  = col_cnt;
        r  = row_cnt;
        up = 32'(row_mem[c]);
        l  = 32'(left_byte);
        ul = 32'(upleft_byte);
        sv = 32'(s);
        n  = 0;
        // Centre and vertical midpoint need a row above, the horizontal one a left column.
        if (r > 0 && c > 0)
        begin
            pts[n] = make_point(2 * c - 1, 2 * r - 1, ul + up + l + sv);
            n++;
        end
        if (r > 0)
        begin
            pts[n] = make_point(2 * c, 2 * r - 1, 2 * (up + sv));
            n++;
        end
        if (c > 0)
        begin
            pts[n] = make_point(2 * c - 1, 2 * r, 2 * (l + sv));
            n++;
        end
        pts[n] = make_point(2 * c, 2 * r, 4 * sv);
        n++;
        for (int k = 0; k < n; k++)
        begin
            p = pts[k];
            p.last = (k == n - 1);
            pending_points.push_back(p);
        end
        upleft_byte = sample_t'(up);
        left_byte   = s;
        row_mem[c]  = s;
        if (c + 1 > written_span)
            written_span = c + 1;
        // A counter at or past its bound (after a shrink) wraps here too.
        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
        end
    endtask

    // Offer one sample, idling the channel at random first; return on its transfer.
    task automatic send_sample(input sample_t s);
        @(negedge clk);
        while (!steady && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        samples_sent++;
        predict_points(s);
    endtask

    // Mostly uniform bytes, with the two extremes weighted up.
    function automatic sample_t rand_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return sample_t'($urandom_range(255));
        endcase
    endfunction

    // Drop valid and wait until every expected point has been checked.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    // Write both dimension registers on back-to-back cycles; the block must be idle.
    task automatic set_dims(input cfg_data_t w, input cfg_data_t h);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SRC_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        dim_width = w;
        cfg_index <= REG_SRC_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        dim_height = h;
        cfg_we <= 1'b0;
        dim_settings++;
    endtask

    // Complete the map in progress, if any, with random samples.
    task automatic finish_map();
        while (col_cnt != 0 || row_cnt != 0)
            send_sample(rand_sample());
    endtask

    // Send one whole map from a map boundary.
    task automatic send_map();
        do
            send_sample(rand_sample());
        while (col_cnt != 0 || row_cnt != 0);
    endtask

    // Defaults after reset, then a shrink in the middle of a row.
    task automatic test_reset_defaults();
        sample_t head[5] = '{8'd255, 8'd255, 8'd0, 8'd128, 8'd1};
        foreach (head[k])
            send_sample(head[k]);
        wait_drained();
        // Column counter is already past the new width: it wraps after the next sample.
        set_dims(11'd3, 11'd2);
        repeat (4)
            send_sample(8'd255);
        wait_drained();
    endtask

    // Zero dimensions act as one: every sample is a map of its own.
    task automatic test_zero_dims();
        set_dims('0, '0);
        send_sample(8'd0);
        send_sample(8'd255);
        send_sample(8'd85);
        wait_drained();
    endtask

    // Alternating bit patterns and extremes over a small map.
    task automatic test_extreme_samples();
        sample_t pat[6] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd170, 8'd85};
        set_dims(11'd2, 11'd3);
        foreach (pat[k])
            send_sample(pat[k]);
        wait_drained();
    endtask

    // Over-range dimensions clamp to the maximum: run into a wide row, then a tall
    // column, and close each map by shrinking it.
    task automatic test_dimension_limits();
        steady = 1'b1;
        set_dims(11'h7FF, 11'd0);
        repeat (EDGE_RUN)
            send_sample(rand_sample());
        wait_drained();
        set_dims(11'd4, 11'd1);
        finish_map();
        wait_drained();
        set_dims(11'd1, 11'h7FF);
        repeat (EDGE_RUN)
            send_sample(rand_sample());
        wait_drained();
        set_dims(11'd1, 11'd1);
        finish_map();
        wait_drained();
        steady = 1'b0;
    endtask

    // Random small maps; some are cut short and resized mid-map.
    task automatic test_random_maps();
        int unsigned start, w, h, pick, cut;
        start = samples_sent;
        while (samples_sent - start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            w = (pick < 8) ? 0 : (pick < 14) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            pick = $urandom_range(99);
            h = (pick < 8) ? 0 : $urandom_range(1, 6);
            set_dims(cfg_data_t'(w), cfg_data_t'(h));
            if ($urandom_range(4) == 0
                && eff_dim(cfg_data_t'(w)) * eff_dim(cfg_data_t'(h)) > 1)
            begin
                cut = $urandom_range(1, eff_dim(cfg_data_t'(w)) * eff_dim(cfg_data_t'(h)) - 1);
                repeat (cut)
                    send_sample(rand_sample());
                wait_drained();
                // Keep the new width inside the already written part of the row memory.
                w = $urandom_range(0, (written_span < 12) ? written_span : 12);
                h = $urandom_range(0, 8);
                set_dims(cfg_data_t'(w), cfg_data_t'(h));
                finish_map();
            end
            else
            begin
                send_map();
            end
            wait_drained();
        end
    endtask

    initial
    begin
        foreach (row_mem[k])
            row_mem[k] = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_dims();
        test_extreme_samples();
        test_dimension_limits();
        test_random_maps();

        repeat (TAIL_CYCLES)
            @(posedge clk);
        $display("tb_top: %0d samples sent, %0d points checked, %0d dimension settings",
                 samples_sent, points_checked, dim_settings);
        $display("tb_top: covered defaults, mid-map shrink, zero and clamped dimensions");
        if (error_count == 0 && pending_points.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
